@@ rtl/mbd_pkg.sv @@
// types and constants shared by the button debouncer modules
// no dependencies; compiled first
`timescale 1ns / 1ps

package mbd_pkg;

    // button set and field widths
    localparam int BUTTON_COUNT = 4;
    localparam int IDX_W        = 2;
    localparam int TICKS_W      = 20;

    // apb register map
    localparam int   ADDR_W          = 3;
    localparam int   DATA_W          = 32;
    localparam logic REG_IDX_DEBOUNCE = 1'b0;

    localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = 20'd20000;

    // input command codes
    localparam logic CMD_PIN  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // one input item
    typedef struct packed {
        logic             command;
        logic [IDX_W-1:0] button_index;
        logic             pin_level;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic [IDX_W-1:0]        changed_button;
        logic [BUTTON_COUNT-1:0] pressed_mask;
        logic                    last_of_run;
    } out_item_t;

    // all commits of one tick, handed to the emitter
    typedef struct packed {
        logic [BUTTON_COUNT-1:0] expired;
        logic [BUTTON_COUNT-1:0] old_mask;
        logic [BUTTON_COUNT-1:0] new_mask;
    } run_t;

endpackage

@@ rtl/multi_button_debouncer.sv @@
// top level of the four-button debouncer: input register, per-button timers, apb register
// depends on mbd_pkg and mbd_emit
`timescale 1ns / 1ps

// Debounces four active-low buttons. An input transfer is either a pin change
// (button index and raw level) or a time tick. A changed level restarts that
// button's timer at debounce_ticks (apb byte address 0, 20 bits, reset 20000,
// zero acts as one); a tick counts every armed timer down, and each timer that
// reaches zero commits its button and yields one result carrying the index and
// the whole pressed mask, in ascending button order with the last one flagged.
// An item is taken into an input register and processed from there, so one
// item per cycle is accepted unless item_stall holds it. Results leave at one
// per cycle while result_stall is low, through a two-run queue; a tick that
// commits buttons waits in the input register while that queue is full.

module multi_button_debouncer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  mbd_pkg::in_item_t          item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output mbd_pkg::out_item_t         result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mbd_pkg::ADDR_W-1:0] paddr,
    input  logic [mbd_pkg::DATA_W-1:0] pwdata,
    output logic [mbd_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import mbd_pkg::*;

    logic                    in_valid_reg, in_valid_next;
    in_item_t                in_reg;
    logic [TICKS_W-1:0]      ticks_reg;
    logic [BUTTON_COUNT-1:0] committed_reg, committed_next;
    logic [BUTTON_COUNT-1:0] pending_reg, pending_next;
    logic [BUTTON_COUNT-1:0] armed_reg, armed_next;
    logic [TICKS_W-1:0]      cnt_reg [BUTTON_COUNT];
    logic [TICKS_W-1:0]      cnt_next [BUTTON_COUNT];

    logic [TICKS_W-1:0]      dec [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] expire;
    logic [BUTTON_COUNT-1:0] armed_zero;
    logic [TICKS_W-1:0]      arm_val;
    logic                    accept;
    logic                    proc_ok;
    logic                    proc_fire;
    logic                    is_tick;
    logic                    new_pend;
    logic                    run_push;
    logic                    run_full;
    logic                    cfg_write;
    run_t                    run_in;

    // apb register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_IDX_DEBOUNCE);
    assign prdata    = (paddr[2] == REG_IDX_DEBOUNCE) ? DATA_W'(ticks_reg) : '0;

    // input handshake
    assign is_tick    = (in_reg.command == CMD_TICK);
    assign proc_ok    = !is_tick || (expire == '0) || !run_full;
    assign proc_fire  = in_valid_reg && proc_ok;
    assign item_stall = in_valid_reg && !proc_ok;
    assign accept     = item_valid && !item_stall;
    assign in_valid_next = accept || (in_valid_reg && !proc_ok);

    // per-button countdown and expiry on a tick
    always_comb
    begin
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            dec[i] = cnt_reg[i] - {{(TICKS_W-1){1'b0}}, (cnt_reg[i] != '0)};
            expire[i] = armed_reg[i] && (dec[i] == '0);
            armed_zero[i] = armed_reg[i] && (cnt_reg[i] == '0);
        end
    end

    // state update for the item in the input register
    always_comb
    begin
        arm_val        = (ticks_reg == '0) ? TICKS_W'(1) : ticks_reg;
        new_pend       = ~in_reg.pin_level;
        committed_next = committed_reg;
        pending_next   = pending_reg;
        armed_next     = armed_reg;
        cnt_next       = cnt_reg;

        if (proc_fire && !is_tick)
        begin
            pending_next[in_reg.button_index] = new_pend;
            if (new_pend != committed_reg[in_reg.button_index])
            begin
                cnt_next[in_reg.button_index]   = arm_val;
                armed_next[in_reg.button_index] = 1'b1;
            end
            else
            begin
                cnt_next[in_reg.button_index]   = '0;
                armed_next[in_reg.button_index] = 1'b0;
            end
        end
        else if (proc_fire)
        begin
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                if (armed_reg[i])
                begin
                    cnt_next[i] = dec[i];
                end
                if (expire[i])
                begin
                    armed_next[i]     = 1'b0;
                    committed_next[i] = pending_reg[i];
                end
            end
        end
    end

    // hand the commits of a tick to the emitter
    assign run_push        = proc_fire && is_tick && (expire != '0);
    assign run_in.expired  = expire;
    assign run_in.old_mask = committed_reg;
    assign run_in.new_mask = committed_next;

    mbd_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .run_push     (run_push),
        .run_in       (run_in),
        .run_full     (run_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            ticks_reg     <= DEBOUNCE_RESET;
            committed_reg <= '0;
            pending_reg   <= '0;
            armed_reg     <= '0;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            committed_reg <= committed_next;
            pending_reg   <= pending_next;
            armed_reg     <= armed_next;
            cnt_reg       <= cnt_next;
            if (cfg_write)
            begin
                ticks_reg <= pwdata[TICKS_W-1:0];
            end
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
    end

    // a pin change never alters the committed mask
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && !is_tick) |=> (committed_reg == $past(committed_reg)))
        else $error("committed mask changed on a pin change");

    // an armed timer always holds a nonzero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (armed_zero == '0))
        else $error("armed timer with zero count");

    // a run is never pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        run_push |-> !run_full)
        else $error("commit run pushed into full queue");

endmodule

@@ rtl/mbd_emit.sv @@
// result emitter: queues the commit runs of ticks and sends one result per transfer
// depends on mbd_pkg
`timescale 1ns / 1ps

module mbd_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              run_push,
    input  mbd_pkg::run_t     run_in,
    output logic              run_full,
    output logic              result_valid,
    input  logic              result_stall,
    output mbd_pkg::out_item_t result
);
    import mbd_pkg::*;

    run_t                    q_reg [2];
    logic                    wr_ptr_reg, wr_ptr_next;
    logic                    rd_ptr_reg, rd_ptr_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic [BUTTON_COUNT-1:0] done_reg, done_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_reg, out_next;

    run_t                    head;
    logic [BUTTON_COUNT-1:0] remaining;
    logic [BUTTON_COUNT-1:0] sel_bit;
    logic [BUTTON_COUNT-1:0] le_mask;
    logic [IDX_W-1:0]        sel_idx;
    logic                    load;
    logic                    last;
    logic                    pop;

    assign run_full     = (cnt_reg == 2'd2);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // lowest pending commit of the head run
    always_comb
    begin
        head      = q_reg[rd_ptr_reg];
        remaining = head.expired & ~done_reg;
        sel_idx   = '0;
        for (int i = BUTTON_COUNT - 1; i >= 0; i--)
        begin
            if (remaining[i])
            begin
                sel_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            sel_bit[i] = (IDX_W'(i) == sel_idx);
            le_mask[i] = (IDX_W'(i) <= sel_idx);
        end
        last = ((remaining & ~sel_bit) == '0);
    end

    // output register load and queue pointers
    always_comb
    begin
        load           = (cnt_reg != 2'd0) && (!out_valid_reg || !result_stall);
        pop            = load && last;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        done_next      = done_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        cnt_next       = cnt_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next          = 1'b1;
            out_next.changed_button = sel_idx;
            out_next.pressed_mask   = (head.new_mask & le_mask) | (head.old_mask & ~le_mask);
            out_next.last_of_run    = last;
            done_next               = pop ? '0 : (done_reg | sel_bit);
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (run_push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (run_push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !run_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            cnt_reg       <= 2'd0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (run_push)
        begin
            q_reg[wr_ptr_reg] <= run_in;
        end
    end

endmodule

@@ verif/multi_button_debouncer_tb.sv @@
// self-checking testbench for the four-button debouncer: directed table, then random phases
// depends on mbd_pkg and the multi_button_debouncer rtl
`timescale 1ns / 1ps

module multi_button_debouncer_tb;

    import mbd_pkg::*;

    // raw pin levels, buttons are active low
    localparam logic LVL_DOWN = 1'b0;
    localparam logic LVL_UP   = 1'b1;

    localparam logic [ADDR_W-1:0] DEBOUNCE_ADDR = ADDR_W'(4 * int'(REG_IDX_DEBOUNCE));
    localparam logic [ADDR_W-1:0] SPARE_ADDR    = ADDR_W'(4 * (int'(REG_IDX_DEBOUNCE) + 1));

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RESET_ROWS    = 4;
    localparam int DIR_ROWS      = 26;
    localparam int PHASES        = 7;
    localparam int RANDOM_PHASE  = 4;

    // one directed row: the transfer, and a typed-in result where it is obvious
    typedef struct packed {
        in_item_t  stim;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    localparam out_item_t NONE = '0;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // still at the reset count: nothing can commit
        '{'{CMD_TICK, 2'd0, LVL_UP},   1'b0, NONE},
        '{'{CMD_PIN,  2'd2, LVL_DOWN}, 1'b0, NONE},
        '{'{CMD_TICK, 2'd0, LVL_UP},   1'b0, NONE},
        '{'{CMD_PIN,  2'd2, LVL_UP},   1'b0, NONE},
        // zero count acts as one tick
        '{'{CMD_PIN,  2'd0, LVL_DOWN}, 1'b0, NONE},
        '{'{CMD_TICK, 2'd0, LVL_UP},   1'b1, '{2'd0, 4'b0001, 1'b1}},
        '{'{CMD_PIN,  2'd0, LVL_DOWN}, 1'b0, NONE},
        '{'{CMD_TICK, 2'd1, LVL_DOWN}, 1'b0, NONE},
        // three commits in one tick
        '{'{CMD_PIN,  2'd1, LVL_DOWN}, 1'b0, NONE},
        '{'{CMD_PIN,  2'd2, LVL_DOWN}, 1'b0, NONE},
        '{'{CMD_PIN,  2'd3, LVL_DOWN}, 1'b0, NONE},
        '{'{CMD_TICK, 2'd3, LVL_UP},   1'b0, NONE},
        // all four released together
        '{'{CMD_PIN,  2'd0, LVL_UP},   1'b0, NONE},
        '{'{CMD_PIN,  2'd1, LVL_UP},   1'b0, NONE},
        '{'{CMD_PIN,  2'd2, LVL_UP},   1'b0, NONE},
        '{'{CMD_PIN,  2'd3, LVL_UP},   1'b0, NONE},
        '{'{CMD_TICK, 2'd2, LVL_DOWN}, 1'b0, NONE},
        // bounce back before expiry cancels the timer
        '{'{CMD_PIN,  2'd2, LVL_DOWN}, 1'b0, NONE},
        '{'{CMD_PIN,  2'd2, LVL_UP},   1'b0, NONE},
        '{'{CMD_TICK, 2'd0, LVL_UP},   1'b0, NONE},
        '{'{CMD_PIN,  2'd3, LVL_DOWN}, 1'b0, NONE},
        '{'{CMD_TICK, 2'd0, LVL_UP},   1'b1, '{2'd3, 4'b1000, 1'b1}},
        '{'{CMD_PIN,  2'd3, LVL_UP},   1'b0, NONE},
        '{'{CMD_PIN,  2'd0, LVL_DOWN}, 1'b0, NONE},
        '{'{CMD_TICK, 2'd1, LVL_UP},   1'b0, NONE},
        // left armed across the next register write
        '{'{CMD_PIN,  2'd1, LVL_DOWN}, 1'b0, NONE}
    };

    // register value per random phase, upper bits of the first one must be dropped
    localparam logic [31:0] PHASE_WORDS [PHASES] = '{
        32'hFFF0_0003, 32'h000F_FFFF, 32'd1, 32'd2, 32'd0, 32'd5, 32'd0
    };
    localparam int PHASE_ITEMS [PHASES] = '{50, 20, 50, 50, 50, 40, 40};

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_stall;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;
    logic      psel = 1'b0;
    logic      penable = 1'b0;
    logic      pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic      pready;

    // debouncer state as the predictor sees it
    logic [TICKS_W-1:0]      db_ticks = DEBOUNCE_RESET;
    logic [BUTTON_COUNT-1:0] held_mask = '0;
    logic [BUTTON_COUNT-1:0] want_mask = '0;
    logic [TICKS_W-1:0]      countdown [BUTTON_COUNT] = '{default: '0};
    logic [BUTTON_COUNT-1:0] armed = '0;

    out_item_t commit_run [$];
    out_item_t expected_commits [$];
    out_item_t oldest_commit;

    int  mismatch_count = 0;
    int  quiet_cycles = 0;
    int  sent_items = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    int  stall_left = 0;
    bit  calm = 1'b0;

    multi_button_debouncer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predicted commits of one accepted transfer, left in commit_run
    task automatic predict_debounce(input in_item_t it);
        int b;
        out_item_t r;
        commit_run.delete();
        if (it.command == CMD_PIN)
        begin
            b = int'(it.button_index);
            if (b < BUTTON_COUNT)
            begin
                want_mask[b] = ~it.pin_level;
                if (want_mask[b] != held_mask[b])
                begin
                    countdown[b] = (db_ticks == '0) ? TICKS_W'(1) : db_ticks;
                    armed[b] = 1'b1;
                end
                else
                begin
                    countdown[b] = '0;
                    armed[b] = 1'b0;
                end
            end
        end
        else
        begin
            for (b = 0; b < BUTTON_COUNT; b++)
            begin
                if (armed[b])
                begin
                    if (countdown[b] != '0)
                        countdown[b] = countdown[b] - TICKS_W'(1);
                    if (countdown[b] == '0)
                    begin
                        armed[b] = 1'b0;
                        held_mask[b] = want_mask[b];
                        r.changed_button = IDX_W'(b);
                        r.pressed_mask = held_mask;
                        r.last_of_run = 1'b0;
                        commit_run.push_back(r);
                    end
                end
            end
            if (commit_run.size() > 0)
                commit_run[commit_run.size() - 1].last_of_run = 1'b1;
        end
    endtask

    // one input transfer, with an optional idle burst in front
    task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
        if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        sent_items++;
        predict_debounce(it);
        if (typed)
            expected_commits.push_back(want);
        else
            foreach (commit_run[i]) expected_commits.push_back(commit_run[i]);
    endtask

    // stop sending, wait for every expected commit, then let the pipe settle
    task automatic drain_commits();
        item_valid <= 1'b0;
        while (expected_commits.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write, then read the debounce register back
    task automatic program_debounce(input logic [ADDR_W-1:0] addr, input logic [31:0] word);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr == DEBOUNCE_ADDR)
            db_ticks = word[TICKS_W-1:0];
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= DEBOUNCE_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== DATA_W'(db_ticks))
        begin
            $error("debounce_ticks readback: expected %0d, got %0d", db_ticks, prdata);
            mismatch_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // compare each result transfer with the oldest expected commit
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_commits.size() == 0)
            begin
                $error("unexpected result: button %0d mask %b last %b",
                       result.changed_button, result.pressed_mask, result.last_of_run);
                mismatch_count++;
            end
            else
            begin
                oldest_commit = expected_commits.pop_front();
                if (result.changed_button !== oldest_commit.changed_button)
                begin
                    $error("changed_button: expected %0d, got %0d",
                           oldest_commit.changed_button, result.changed_button);
                    mismatch_count++;
                end
                if (result.pressed_mask !== oldest_commit.pressed_mask)
                begin
                    $error("pressed_mask: expected %b, got %b",
                           oldest_commit.pressed_mask, result.pressed_mask);
                    mismatch_count++;
                end
                if (result.last_of_run !== oldest_commit.last_of_run)
                begin
                    $error("last_of_run: expected %b, got %b",
                           oldest_commit.last_of_run, result.last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver stall bursts at random
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (!calm && $urandom_range(0, 99) < stall_pct)
        begin
            result_stall <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end
        else
            result_stall <= 1'b0;
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("[multi_button_debouncer] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int ph;
        int k;
        int bounces;
        int nticks;
        int eff;
        int phase_end;
        logic tgt;
        logic [IDX_W-1:0] btn;
        in_item_t stim;
        logic [31:0] word;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, the register goes to zero after the reset rows
        for (k = 0; k < DIR_ROWS; k++)
        begin
            if (k == RESET_ROWS)
            begin
                drain_commits();
                program_debounce(DEBOUNCE_ADDR, 32'd0);
            end
            send_item(DIR_TABLE[k].stim, DIR_TABLE[k].typed, DIR_TABLE[k].want);
        end
        drain_commits();

        // a write past the only register is ignored
        program_debounce(SPARE_ADDR, 32'h0000_0007);

        // random phases, each at its own debounce count and idle mix
        for (ph = 0; ph < PHASES; ph++)
        begin
            word = (ph == RANDOM_PHASE) ? 32'($urandom_range(1, 6)) : PHASE_WORDS[ph];
            program_debounce(DEBOUNCE_ADDR, word);
            calm = (ph == PHASES - 1);
            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            eff = (db_ticks == '0) ? 1 : int'(db_ticks);
            phase_end = sent_items + PHASE_ITEMS[ph];
            while (sent_items < phase_end)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    // bouncing edge that settles, then one to six ticks, not always enough to commit it
                    btn = IDX_W'($urandom_range(0, BUTTON_COUNT - 1));
                    tgt = 1'($urandom_range(0, 1));
                    bounces = $urandom_range(0, 3);
                    for (k = bounces; k >= 0; k--)
                    begin
                        stim = '{CMD_PIN, btn, tgt ^ 1'(k % 2)};
                        send_item(stim, 1'b0, NONE);
                    end
                    nticks = $urandom_range(1, (eff >= 6) ? 6 : eff + 1);
                    for (k = 0; k < nticks; k++)
                    begin
                        stim = in_item_t'({CMD_TICK, 3'($urandom_range(0, 7))});
                        send_item(stim, 1'b0, NONE);
                    end
                end
                else
                begin
                    stim = in_item_t'(4'($urandom_range(0, 15)));
                    send_item(stim, 1'b0, NONE);
                end
                // in phase 2, around its middle, hold the sender until every commit is out
                if (ph == 2 && sent_items >= phase_end - PHASE_ITEMS[ph] / 2
                    && sent_items < phase_end - PHASE_ITEMS[ph] / 2 + 3)
                begin
                    item_valid <= 1'b0;
                    @(posedge clk);
                    while (expected_commits.size() != 0) @(posedge clk);
                end
            end
            drain_commits();
        end

        if (mismatch_count == 0)
            $display("[multi_button_debouncer] OK");
        else
            $display("[multi_button_debouncer] ERROR");
        $finish;
    end

endmodule
